>>> hw/rtl/freq_shift_metal_detect_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the frequency-shift metal detector
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef FREQ_SHIFT_METAL_DETECT_MACROS_SVH
`define FREQ_SHIFT_METAL_DETECT_MACROS_SVH

// Same-cycle implication.
`define FSMD_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FSMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/fsmd_pkg.sv
// ---------------------------------------------------------------------------
// fsmd_pkg
// Types and constants shared by the frequency-shift metal detector.
// ---------------------------------------------------------------------------
package fsmd_pkg;

	localparam int SAMPLES_PER_AVERAGE = 20;

	localparam int WIDTH_W  = 16;
	localparam int PERIOD_W = WIDTH_W + 1;
	localparam int FREQ_W   = 20;
	localparam int HOLD_W   = 16;
	localparam int CNT_W    = 5;
	localparam int SUM_W    = 25;
	localparam int TICK_W   = 17;
	localparam int DIV_W    = SUM_W;
	localparam int DIV_CNT_W = 5;
	localparam int IDX_W    = 3;

	// The mean is the sum times a reciprocal of the average size rounded up,
	// shifted right. With the shift at SUM_W + CNT_W the rounding error stays
	// below one for every sum that fits in SUM_W bits and every size up to 31.
	localparam int MEAN_SHIFT = SUM_W + CNT_W;
	localparam int RECIP_W    = MEAN_SHIFT + 1;

	localparam longint unsigned MEAN_RECIP_FULL =
		((longint'(1) << MEAN_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;

	localparam logic [DIV_W-1:0]     MICROS_PER_SECOND = DIV_W'(1000000);
	localparam logic [TICK_W-1:0]    TICKS_MAX   = {TICK_W{1'b1}};
	localparam logic [CNT_W-1:0]     MEAN_LEN    = CNT_W'(SAMPLES_PER_AVERAGE);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(DIV_W - 1);
	localparam logic [RECIP_W-1:0]   MEAN_RECIP  = RECIP_W'(MEAN_RECIP_FULL);

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_REJECT_BELOW  = 3'd0;
	localparam logic [IDX_W-1:0] REG_REJECT_ABOVE  = 3'd1;
	localparam logic [IDX_W-1:0] REG_ARM_BELOW     = 3'd2;
	localparam logic [IDX_W-1:0] REG_RELEASE_ABOVE = 3'd3;
	localparam logic [IDX_W-1:0] REG_HOLD_TICKS    = 3'd4;

	localparam logic [FREQ_W-1:0] RST_REJECT_BELOW  = FREQ_W'(8000);
	localparam logic [FREQ_W-1:0] RST_REJECT_ABOVE  = FREQ_W'(9500);
	localparam logic [FREQ_W-1:0] RST_ARM_BELOW     = FREQ_W'(8900);
	localparam logic [FREQ_W-1:0] RST_RELEASE_ABOVE = FREQ_W'(9000);
	localparam logic [HOLD_W-1:0] RST_HOLD_TICKS    = HOLD_W'(100);

	// Item kinds decided by the front end.
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_NULL   = 2'd1;
	localparam logic [1:0] KIND_SAMPLE = 2'd2;

	typedef struct packed {
		logic [1:0]          kind;
		logic [PERIOD_W-1:0] period;
	} item_t;

	typedef struct packed {
		logic [FREQ_W-1:0] reject_below_hz;
		logic [FREQ_W-1:0] reject_above_hz;
		logic [FREQ_W-1:0] arm_below_hz;
		logic [FREQ_W-1:0] release_above_hz;
		logic [HOLD_W-1:0] hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> hw/rtl/fsmd_if.sv
// ---------------------------------------------------------------------------
// fsmd channel interfaces
// Input item, result item and configuration write channels.
// ---------------------------------------------------------------------------
interface fsmd_in_if import fsmd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               mode;
	logic [WIDTH_W-1:0] high_width_us;
	logic [WIDTH_W-1:0] low_width_us;

	modport source(output valid, mode, high_width_us, low_width_us, input ready);
	modport sink(input valid, mode, high_width_us, low_width_us, output ready);
endinterface

interface fsmd_out_if import fsmd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              detect_level;
	logic              armed_flag;
	logic              average_ready;
	logic [FREQ_W-1:0] average_hz;

	modport source(output valid, detect_level, armed_flag, average_ready, average_hz,
		input ready);
	modport sink(input valid, detect_level, armed_flag, average_ready, average_hz,
		output ready);
endinterface

interface fsmd_cfg_if import fsmd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [FREQ_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/freq_shift_metal_detect.sv
// ---------------------------------------------------------------------------
// freq_shift_metal_detect: frequency-shift metal detector with hysteresis
// A tick or zero-period sample passes the queue and then the result register; another
// sample also passes the divider, and one that completes an average the mean state.
// The back end takes one item at a time, a new one only after the last has finished;
// with the result side ready it takes a tick or zero-period sample per cycle.
// Reset: arst_n clears the control state and reloads the register defaults at once.
// ---------------------------------------------------------------------------
module freq_shift_metal_detect import fsmd_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	fsmd_in_if.sink     samples,
	fsmd_out_if.source  results,
	fsmd_cfg_if.sink    cfg
);

	// Configuration registers. Writes are always taken; the user must configure
	// the block only while it has nothing in flight; the block does not enforce it.
	cfg_t cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reject_below_hz  <= RST_REJECT_BELOW;
			cfg_q.reject_above_hz  <= RST_REJECT_ABOVE;
			cfg_q.arm_below_hz     <= RST_ARM_BELOW;
			cfg_q.release_above_hz <= RST_RELEASE_ABOVE;
			cfg_q.hold_ticks       <= RST_HOLD_TICKS;
		end else if (cfg.valid) begin
			// An index beyond the register list is ignored.
			unique case (cfg.index)
				REG_REJECT_BELOW:  cfg_q.reject_below_hz  <= cfg.data;
				REG_REJECT_ABOVE:  cfg_q.reject_above_hz  <= cfg.data;
				REG_ARM_BELOW:     cfg_q.arm_below_hz     <= cfg.data;
				REG_RELEASE_ABOVE: cfg_q.release_above_hz <= cfg.data;
				REG_HOLD_TICKS:    cfg_q.hold_ticks       <= cfg.data[HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The front end forms the period from the two pulse widths and tags each
	// transfer as a tick, a zero-period sample or a sample to be divided.
	item_t front_item;
	logic  front_push;
	logic  queue_full;

	fsmd_front u_front (
		.samples (samples),
		.full    (queue_full),
		.push    (front_push),
		.item    (front_item)
	);

	// A short queue lets the front end keep taking transfers while the back
	// end is busy dividing.
	item_t queue_item;
	logic  queue_empty;
	logic  queue_pop;

	fsmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.wdata  (front_item),
		.full   (queue_full),
		.pop    (queue_pop),
		.rdata  (queue_item),
		.empty  (queue_empty)
	);

	// The back end runs the divider once per nonzero-period sample to get its frequency.
	// A sample that completes an average also passes the mean state, a
	// reciprocal multiplication of the registered sum. The back end then
	// updates the armed state and the hold count, and writes one result into
	// its output register per item.
	fsmd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item    (queue_item),
		.empty   (queue_empty),
		.pop     (queue_pop),
		.results (results)
	);

endmodule

>>> hw/rtl/fsmd_front.sv
// ---------------------------------------------------------------------------
// fsmd_front
// Accepts input items, forms the period and classifies each item.
// ---------------------------------------------------------------------------
module fsmd_front import fsmd_pkg::*; (
	fsmd_in_if.sink samples,
	input  logic    full,
	output logic    push,
	output item_t   item
);

	logic [PERIOD_W-1:0] period;

	assign period = {1'b0, samples.high_width_us} + {1'b0, samples.low_width_us};

	assign samples.ready = !full;
	assign push = samples.valid && !full;

	always_comb begin
		item.period = period;
		if (samples.mode) begin
			item.kind = KIND_TICK;
		end else if (period == '0) begin
			item.kind = KIND_NULL;
		end else begin
			item.kind = KIND_SAMPLE;
		end
	end

endmodule

>>> hw/rtl/fsmd_queue.sv
// ---------------------------------------------------------------------------
// fsmd_queue
// Two-entry queue between the front end and the back end.
// ---------------------------------------------------------------------------
module fsmd_queue import fsmd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	input  logic  pop,
	output item_t rdata,
	output logic  empty
);

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> hw/rtl/fsmd_div.sv
// ---------------------------------------------------------------------------
// fsmd_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fsmd_div import fsmd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_W-1:0]    dividend,
	input  logic [PERIOD_W-1:0] divisor,
	output logic [DIV_W-1:0]    quotient,
	output div_stat_t           stat
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     dvd_q;
	logic [PERIOD_W:0]    rem_q;
	logic [PERIOD_W-1:0]  dvs_q;
	logic [PERIOD_W:0]    rem_sh;
	logic [PERIOD_W:0]    diff;
	logic                 ge;

	// The remainder stays below the divisor, so it never uses its top bit
	// before the shift.
	assign rem_sh = {rem_q[PERIOD_W-1:0], dvd_q[DIV_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign ge     = (rem_sh >= {1'b0, dvs_q});

	assign quotient  = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff : rem_sh;
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

endmodule

>>> hw/rtl/fsmd_back.sv
// ---------------------------------------------------------------------------
// fsmd_back
// Executes queued items: frequency, averaging, arming and hold timing.
// ---------------------------------------------------------------------------
`include "freq_shift_metal_detect_macros.svh"

module fsmd_back import fsmd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  item_t item,
	input  logic  empty,
	output logic  pop,
	fsmd_out_if.source results
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FREQ = 2'd1;
	localparam logic [1:0] ST_MEAN = 2'd2;

	logic [1:0]        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
	logic [SUM_W-1:0]  sum_q, sum_d, sum_add;
	logic              armed_q, armed_d;
	logic [TICK_W-1:0] ticks_q, ticks_d;
	logic              detect_q, detect_d;

	logic              out_valid_q;
	logic              out_detect_q;
	logic              out_armed_q;
	logic              out_avg_rdy_q;
	logic [FREQ_W-1:0] out_avg_q;

	logic              slot_free;
	logic              finish;
	logic              avg_rdy;
	logic [FREQ_W-1:0] avg;
	logic [FREQ_W-1:0] freq;
	logic              in_window;

	logic [SUM_W+RECIP_W-1:0] mean_prod;

	logic                div_start;
	logic [DIV_W-1:0]    div_dvd;
	logic [PERIOD_W-1:0] div_dvs;
	logic [DIV_W-1:0]    div_quo;
	div_stat_t           div_stat;

	fsmd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// Only this module writes the result register, so a slot that is free
	// when an item is popped stays free until that item finishes.
	assign slot_free = !out_valid_q || results.ready;

	assign freq      = div_quo[FREQ_W-1:0];
	assign in_window = (freq > cfg.reject_below_hz) && (freq < cfg.reject_above_hz);
	assign sum_add   = sum_q + {{(SUM_W-FREQ_W){1'b0}}, freq};
	assign cnt_inc   = cnt_q + CNT_W'(1);

	// The mean of a completed average comes from the registered sum by a
	// reciprocal multiplication.
	assign mean_prod = {{RECIP_W{1'b0}}, sum_q} * {{SUM_W{1'b0}}, MEAN_RECIP};

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		sum_d     = sum_q;
		armed_d   = armed_q;
		ticks_d   = ticks_q;
		detect_d  = detect_q;
		pop       = 1'b0;
		finish    = 1'b0;
		avg_rdy   = 1'b0;
		avg       = '0;
		div_start = 1'b0;
		div_dvd   = MICROS_PER_SECOND;
		div_dvs   = item.period;

		unique case (state_q)
			ST_IDLE: begin
				if (!empty && slot_free) begin
					pop = 1'b1;
					unique case (item.kind)
						KIND_TICK: begin
							if (armed_q && ticks_q != TICKS_MAX) begin
								ticks_d = ticks_q + TICK_W'(1);
							end
							finish = 1'b1;
						end
						KIND_SAMPLE: begin
							div_start = 1'b1;
							state_d   = ST_FREQ;
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			ST_FREQ: begin
				if (div_stat.done) begin
					if (in_window && cnt_inc == MEAN_LEN) begin
						// The last sample of an average: the full sum is registered
						// in the sum register, and the mean state takes the mean from it.
						sum_d   = sum_add;
						cnt_d   = '0;
						state_d = ST_MEAN;
					end else begin
						if (in_window) begin
							sum_d = sum_add;
							cnt_d = cnt_inc;
						end
						finish  = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_MEAN: begin
				avg     = mean_prod[MEAN_SHIFT +: FREQ_W];
				avg_rdy = 1'b1;
				if (avg < cfg.arm_below_hz) begin
					if (!armed_q) begin
						armed_d = 1'b1;
						ticks_d = '0;
					end
				end else if (avg > cfg.release_above_hz) begin
					armed_d  = 1'b0;
					detect_d = 1'b0;
				end
				sum_d   = '0;
				cnt_d   = '0;
				finish  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (finish && armed_d && ticks_d > {1'b0, cfg.hold_ticks}) begin
			detect_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			armed_q     <= 1'b0;
			ticks_q     <= '0;
			detect_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			sum_q    <= sum_d;
			armed_q  <= armed_d;
			ticks_q  <= ticks_d;
			detect_q <= detect_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_detect_q  <= detect_d;
			out_armed_q   <= armed_d;
			out_avg_rdy_q <= avg_rdy;
			out_avg_q     <= avg;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.detect_level  = out_detect_q;
	assign results.armed_flag    = out_armed_q;
	assign results.average_ready = out_avg_rdy_q;
	assign results.average_hz    = out_avg_q;

	`FSMD_ASSERT_IMPLY(a_finish_slot, finish, slot_free, "result written over a pending transfer")
	`FSMD_ASSERT_NEXT(a_div_started, div_start, div_stat.busy, "divider did not start")
	`FSMD_ASSERT_IMPLY(a_detect_armed, detect_q, armed_q, "detect high while disarmed")
	`FSMD_ASSERT_IMPLY(a_cnt_range, 1'b1, cnt_q < MEAN_LEN, "sample count passed the average size")

endmodule
